/* sv/dbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbn_pkg
// Shared types, codes and the flag address helper for the dissemination
// barrier node.
// ----------------------------------------------------------------------------
package dbn_pkg;

    // Sizing
    localparam int MAX_ROUNDS = 17;
    localparam int FLAG_DEPTH = 2 * MAX_ROUNDS;
    localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
    localparam int ID_W       = 16;
    localparam int FLAG_W     = ID_W - 1;
    localparam int RANK_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int ROUND_W    = 5;
    localparam int KIND_W     = 2;
    localparam int TYPE_W     = 2;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Request types
    localparam logic [TYPE_W-1:0] REQ_LOCAL   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SIGNAL  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CROSSED = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_UNUSED  = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CROSS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd2;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_FETCH     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WRITE     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_READ      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SIGNAL    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CROSS_REQ = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NOTE      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FLUSH     = 4'd8;

    // Datapath operation of a control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_WRITE,
        OP_READ,
        OP_CHECK,
        OP_SIGNAL,
        OP_CROSS_REQ,
        OP_NOTE,
        OP_FLUSH
    } op_t;

    // Jump condition of a control word
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IDLE,
        COND_IS_CROSSED,
        COND_ROUND_END,
        COND_NO_MATCH
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Channel payloads
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [ROUND_W-1:0] in_round;
        logic [ID_W-1:0]    in_barrier_id;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  out_kind;
        logic [RANK_W-1:0]  dest_node;
        logic [ROUND_W-1:0] out_round;
        logic [ID_W-1:0]    out_barrier_id;
        logic               last;
    } res_t;

    // Sequencer to result queue
    typedef struct packed {
        logic push;
        logic flush;
        res_t item;
    } push_t;

    // Result queue to sequencer
    typedef struct packed {
        logic stall;
        logic pend_valid;
    } queue_status_t;

    // Flag store address: parity selects the bank, round the entry
    function automatic logic [FLAG_AW-1:0] flag_addr(input logic parity,
                                                     input logic [ROUND_W-1:0] rnd);
        logic [FLAG_AW-1:0] base;
        base = parity ? FLAG_AW'(MAX_ROUNDS) : '0;
        return base + FLAG_AW'(rnd);
    endfunction

endpackage
`default_nettype wire

/* sv/dbn_ucode_rom.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbn_ucode_rom
// Control store of the barrier sequencer: one control word per step.
// ----------------------------------------------------------------------------
module dbn_ucode_rom
    import dbn_pkg::*;
(
    input  wire logic [STEP_W-1:0] step,
    output ctrl_word_t             ctrl
);

    // Fetch, dispatch, write, read/check/signal per round, cross, note, flush
    always_comb
    begin
        unique case (step)
            STEP_FETCH:     ctrl = '{op: OP_FETCH,     cond: COND_IDLE,       target: STEP_FETCH};
            STEP_DISPATCH:  ctrl = '{op: OP_NOP,       cond: COND_IS_CROSSED, target: STEP_NOTE};
            STEP_WRITE:     ctrl = '{op: OP_WRITE,     cond: COND_NEVER,      target: STEP_FETCH};
            STEP_READ:      ctrl = '{op: OP_READ,      cond: COND_ROUND_END,  target: STEP_CROSS_REQ};
            STEP_CHECK:     ctrl = '{op: OP_CHECK,     cond: COND_NO_MATCH,   target: STEP_CROSS_REQ};
            STEP_SIGNAL:    ctrl = '{op: OP_SIGNAL,    cond: COND_ALWAYS,     target: STEP_READ};
            STEP_CROSS_REQ: ctrl = '{op: OP_CROSS_REQ, cond: COND_ALWAYS,     target: STEP_FLUSH};
            STEP_NOTE:      ctrl = '{op: OP_NOTE,      cond: COND_NEVER,      target: STEP_FETCH};
            STEP_FLUSH:     ctrl = '{op: OP_FLUSH,     cond: COND_ALWAYS,     target: STEP_FETCH};
            default:        ctrl = '{op: OP_NOP,       cond: COND_ALWAYS,     target: STEP_FETCH};
        endcase
    end

endmodule
`default_nettype wire

/* sv/dbn_flag_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbn_flag_store
// Round flag memory, two banks by id parity, with per-entry valid bits.
// An entry not yet written reads as invalid (valid bits are cleared only by reset).
// ----------------------------------------------------------------------------
module dbn_flag_store
    import dbn_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [FLAG_AW-1:0] wr_addr,
    input  wire logic [FLAG_W-1:0]  wr_data,
    input  wire logic               rd_en,
    input  wire logic [FLAG_AW-1:0] rd_addr,
    output logic      [FLAG_W-1:0]  rd_data,
    output logic                    rd_valid
);

    logic [FLAG_W-1:0]     flag_mem [FLAG_DEPTH];
    logic [FLAG_DEPTH-1:0] valid_reg;
    logic [FLAG_DEPTH-1:0] valid_next;
    logic [FLAG_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= flag_mem[rd_addr];
        end
    end

    // Valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_valid_reg;
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule
`default_nettype wire

/* sv/dbn_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbn_result_queue
// Holds the newest result back one slot so the final one can carry last,
// and drives the output register of the result channel.
// ----------------------------------------------------------------------------
module dbn_result_queue
    import dbn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output queue_status_t status,
    output logic         res_valid,
    input  wire logic    res_ready,
    output res_t         res_data
);

    logic pend_valid_reg;
    logic pend_valid_next;
    res_t pend_reg;
    res_t pend_next;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    res_t out_next;
    logic out_free;
    logic need_out;
    logic stall;

    assign out_free = !out_valid_reg || res_ready;
    assign need_out = (push.push || push.flush) && pend_valid_reg;
    assign stall    = need_out && !out_free;

    // Move held result out, load new one
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        if (!stall)
        begin
            if (need_out)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = push.flush;
            end
            if (push.push)
            begin
                pend_valid_next = 1'b1;
                pend_next       = push.item;
            end
            else if (push.flush)
            begin
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign status.stall      = stall;
    assign status.pend_valid = pend_valid_reg;
    assign res_valid         = out_valid_reg;
    assign res_data          = out_reg;

endmodule
`default_nettype wire

/* sv/dissemination_barrier_node.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dissemination_barrier_node
// One node of a dissemination barrier, run by a microcoded sequencer over a
// round flag memory, a peer adder and a one-deep result hold stage.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_valid/req_ready    req_t: type, round, barrier id
//   res      out  res_valid/res_ready    res_t: kind, peer, round, id, last
//   cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// One request at a time. An unknown type is dropped at fetch. Crossed notice:
// fetch, dispatch, note, flush. Entry or signal: fetch, dispatch, flag write,
// one read/check/signal triple per cleared round, a last read (and a check
// when an uncleared flag stops the walk), crossing check, flush.
// res_ready low stalls the sequencer only when a result must move out.
// Reset clears the flag valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dissemination_barrier_node
    import dbn_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_word_t         ctrl;
    queue_status_t      q_status;
    push_t              push;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [RANK_W-1:0]  node_rank_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic [ROUND_W-1:0] round_count_reg;
    req_t               req_reg;
    logic [ROUND_W-1:0] cur_round_reg;
    logic [ROUND_W-1:0] cur_round_next;
    logic [ID_W-1:0]    cur_id_reg;
    logic [ID_W-1:0]    cur_id_next;
    logic [COUNT_W-1:0] peer_sum_reg;

    logic               req_fire;
    logic [ROUND_W-1:0] rc_eff;
    logic               round_end;
    logic               flag_match;
    logic               cond_true;
    logic [ROUND_W-1:0] wr_round;
    logic [ID_W-1:0]    wr_id;
    logic               wr_en;
    logic               rd_en;
    logic [FLAG_W-1:0]  rd_data;
    logic               rd_valid;
    logic [COUNT_W-1:0] peer_red;

    // Control store
    dbn_ucode_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    // Round flags
    dbn_flag_store u_flags (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (flag_addr(wr_id[0], wr_round)),
        .wr_data  (wr_id[ID_W-1:1]),
        .rd_en    (rd_en),
        .rd_addr  (flag_addr(cur_id_reg[0], cur_round_reg)),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    // Result hold and output register
    dbn_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .status    (q_status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Handshakes and status
    assign req_ready  = (step_reg == STEP_FETCH);
    assign req_fire   = req_valid && req_ready;
    assign cfg_ready  = 1'b1;
    assign rc_eff     = (round_count_reg > ROUND_W'(MAX_ROUNDS)) ?
                        ROUND_W'(MAX_ROUNDS) : round_count_reg;
    assign round_end  = (cur_round_reg >= rc_eff);
    assign flag_match = rd_valid && (rd_data == cur_id_reg[ID_W-1:1]);

    // Local entry writes round 0 of the current id
    assign wr_round = (req_reg.req_type == REQ_LOCAL) ? '0 : req_reg.in_round;
    assign wr_id    = (req_reg.req_type == REQ_LOCAL) ? cur_id_reg : req_reg.in_barrier_id;

    // Peer reduction: one conditional subtract of the node count
    assign peer_red = (peer_sum_reg >= node_count_reg) ?
                      (peer_sum_reg - node_count_reg) : peer_sum_reg;

    // Jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_IDLE:       cond_true = !req_fire || (req_data.req_type == REQ_UNUSED);
            COND_IS_CROSSED: cond_true = (req_reg.req_type == REQ_CROSSED);
            COND_ROUND_END:  cond_true = round_end;
            COND_NO_MATCH:   cond_true = !flag_match;
            default:         cond_true = 1'b1;
        endcase
    end

    // Datapath controls from the control word
    always_comb
    begin
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        push           = '0;
        cur_round_next = cur_round_reg;
        cur_id_next    = cur_id_reg;
        unique case (ctrl.op)
            OP_NOP, OP_FETCH, OP_CHECK:
            begin
            end
            OP_WRITE:
            begin
                wr_en = ({1'b0, wr_round} < (ROUND_W + 1)'(MAX_ROUNDS));
            end
            OP_READ:
            begin
                rd_en = !round_end;
            end
            OP_SIGNAL:
            begin
                push.push                = !round_end;
                push.item.out_kind       = KIND_SIGNAL;
                push.item.dest_node      = peer_red[RANK_W-1:0];
                push.item.out_round      = cur_round_reg;
                push.item.out_barrier_id = cur_id_reg;
            end
            OP_CROSS_REQ:
            begin
                push.push          = (cur_round_reg == rc_eff) && (node_rank_reg == '0);
                push.item.out_kind = KIND_CROSS;
            end
            OP_NOTE:
            begin
                push.push          = 1'b1;
                push.item.out_kind = KIND_DONE;
                if (!q_status.stall)
                begin
                    cur_id_next    = cur_id_reg + 1'b1;
                    cur_round_next = '0;
                end
            end
            OP_FLUSH:
            begin
                push.flush = 1'b1;
            end
            default:
            begin
            end
        endcase
        if ((ctrl.op == OP_CHECK) && flag_match)
        begin
            cur_round_next = cur_round_reg + 1'b1;
        end
    end

    // Step counter
    always_comb
    begin
        priority if (q_status.stall)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= STEP_FETCH;
            cur_round_reg   <= '0;
            cur_id_reg      <= '0;
            node_rank_reg   <= '0;
            node_count_reg  <= COUNT_W'(1);
            round_count_reg <= ROUND_W'(1);
        end
        else
        begin
            step_reg      <= step_next;
            cur_round_reg <= cur_round_next;
            cur_id_reg    <= cur_id_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NODE_RANK:   node_rank_reg   <= cfg_data[RANK_W-1:0];
                    CFG_NODE_COUNT:  node_count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_ROUND_COUNT: round_count_reg <= cfg_data[ROUND_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Captured request and peer sum (payload)
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req_data;
        end
        if ((ctrl.op == OP_CHECK) && flag_match)
        begin
            peer_sum_reg <= COUNT_W'(node_rank_reg) + (COUNT_W'(1) << cur_round_reg);
        end
    end

    // Assertions
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !q_status.pend_valid)
        else $error("held result left over when taking a new request");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_round_reg <= ROUND_W'(MAX_ROUNDS))
        else $error("current round beyond the flag store");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_FLUSH)
        else $error("step counter outside the program");

    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (step_reg == STEP_CHECK))
        else $error("flag read not followed by its check step");

endmodule
`default_nettype wire

/* bench/tb_dissemination_barrier_node.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dissemination_barrier_node
// Self-checking bench for one dissemination barrier node. A behavioral copy
// of the node (round flags, current round, barrier id, settings) predicts
// the messages of every accepted request. A monitor compares each delivered
// message with the oldest prediction. Stimulus covers directed corner
// settings, then shuffled barriers with noise, a long output hold-off and a
// final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_dissemination_barrier_node;
    import dbn_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Block ports
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data  = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    dissemination_barrier_node dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Behavioral copy of the node
    logic [ID_W-1:0]    flag_mem [2][MAX_ROUNDS];
    logic [ROUND_W-1:0] at_round;
    logic [ID_W-1:0]    barrier_id;
    logic [RANK_W-1:0]  rank_cfg;
    logic [COUNT_W-1:0] count_cfg;
    logic [ROUND_W-1:0] rounds_cfg;

    // Predicted messages, oldest first
    res_t owed_msgs [$];
    res_t held_msg;
    bit   held_valid;
    int   burst;

    // Run control and bookkeeping
    bit req_gaps;
    bit res_stalls;
    bit hold_request;
    int items_sent;
    int results_checked;
    int settings_used;
    int longest_burst;
    int fail_count;
    res_t want;

    // Rounds actually in play; oversized counts clamp to the store depth
    function int live_rounds();
        return (rounds_cfg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_cfg);
    endfunction

    // Peer for round r: rank + 2^(r-1), one conditional subtract
    function logic [RANK_W-1:0] peer_rank(input logic [ROUND_W-1:0] r);
        logic [17:0] s;
        s = 18'(rank_cfg) + (18'd1 << (r - 5'd1));
        if (s >= 18'(count_cfg))
            s = s - 18'(count_cfg);
        return s[RANK_W-1:0];
    endfunction

    function int rounds_for(input int n);
        int r;
        r = 0;
        while ((1 << r) < n)
            r++;
        return r + 1;
    endfunction

    function req_t make_req(input logic [TYPE_W-1:0] t, input logic [ROUND_W-1:0] rn,
                            input logic [ID_W-1:0] id);
        req_t r;
        r.req_type      = t;
        r.in_round      = rn;
        r.in_barrier_id = id;
        return r;
    endfunction

    function req_t noise_req();
        return make_req(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                        16'($urandom()));
    endfunction

    // Queue one message; the previous one is released without last
    task emit(input logic [KIND_W-1:0] kind, input logic [RANK_W-1:0] dest,
              input logic [ROUND_W-1:0] rn, input logic [ID_W-1:0] id);
        if (held_valid)
            owed_msgs = {owed_msgs, held_msg};
        held_msg                = '0;
        held_msg.out_kind       = kind;
        held_msg.dest_node      = dest;
        held_msg.out_round      = rn;
        held_msg.out_barrier_id = id;
        held_valid              = 1'b1;
        burst++;
    endtask

    // Mark a round flag, then walk every round that is already cleared
    task absorb_signal(input logic [ROUND_W-1:0] rn, input logic [ID_W-1:0] id);
        int rc;
        rc = live_rounds();
        if (rn < MAX_ROUNDS)
            flag_mem[id[0]][rn] = {1'b0, id[ID_W-1:1]};
        while (at_round < rc &&
               flag_mem[barrier_id[0]][at_round] == {1'b0, barrier_id[ID_W-1:1]})
        begin
            at_round++;
            if (at_round < rc)
                emit(KIND_SIGNAL, peer_rank(at_round), at_round, barrier_id);
        end
        if (at_round == rc && rank_cfg == '0)
            emit(KIND_CROSS, '0, '0, '0);
    endtask

    // Predict the messages caused by one accepted request
    task absorb_request(input req_t r);
        burst = 0;
        case (r.req_type)
            REQ_LOCAL:   absorb_signal('0, barrier_id);
            REQ_SIGNAL:  absorb_signal(r.in_round, r.in_barrier_id);
            REQ_CROSSED:
            begin
                barrier_id = barrier_id + 16'd1;
                at_round   = '0;
                emit(KIND_DONE, '0, '0, '0);
            end
            default: ;
        endcase
        if (held_valid)
        begin
            held_msg.last = 1'b1;
            owed_msgs     = {owed_msgs, held_msg};
            held_valid    = 1'b0;
        end
        if (burst > longest_burst)
            longest_burst = burst;
    endtask

    // Offer one request, with an optional idle burst in front
    task send_req(input req_t r);
        if (req_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        absorb_request(r);
        if (r.req_type != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Wait out all predicted messages plus the longest silent request
    task settle();
        req_valid <= 1'b0;
        while (owed_msgs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all three settings back to back once the node is idle
    task set_node(input logic [RANK_W-1:0] rank, input logic [COUNT_W-1:0] count,
                  input logic [ROUND_W-1:0] rounds);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int i;
        idx[0] = CFG_NODE_RANK;   vals[0] = CFG_DATA_W'(rank);
        idx[1] = CFG_NODE_COUNT;  vals[1] = CFG_DATA_W'(count);
        idx[2] = CFG_ROUND_COUNT; vals[2] = CFG_DATA_W'(rounds);
        settle();
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            case (idx[i])
                CFG_NODE_RANK:   rank_cfg   = vals[i][RANK_W-1:0];
                CFG_NODE_COUNT:  count_cfg  = vals[i][COUNT_W-1:0];
                CFG_ROUND_COUNT: rounds_cfg = vals[i][ROUND_W-1:0];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task pick_random_node();
        int unsigned cnt;
        int unsigned rk;
        int unsigned rnds;
        case ($urandom_range(0, 7))
            0:
            begin
                cnt = 65536; rk = $urandom_range(0, 65535); rnds = 17;
            end
            1:
            begin
                cnt = 65536; rk = 65535; rnds = 17;
            end
            2:
            begin
                cnt  = $urandom_range(1, 65536);
                rk   = $urandom_range(0, cnt - 1);
                rnds = rounds_for(cnt);
            end
            3:
            begin
                cnt = 1; rk = 0; rnds = 1;
            end
            default:
            begin
                cnt  = $urandom_range(2, 40);
                rk   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cnt - 1);
                rnds = rounds_for(cnt);
            end
        endcase
        set_node(rk[RANK_W-1:0], cnt[COUNT_W-1:0], rnds[ROUND_W-1:0]);
    endtask

    // One barrier: entry plus a signal per round, then the crossed notice.
    // Unordered runs shuffle, may drop a round, may carry early signals for
    // the next id, and sprinkle random requests in between.
    task run_barrier(input bit ordered);
        req_t seq [$];
        req_t tmp;
        int   rc;
        int   skip;
        int   i;
        int   j;
        logic [ID_W-1:0] id;
        id   = barrier_id;
        rc   = live_rounds();
        skip = 0;
        seq  = {};
        if (!ordered && rc > 2 && $urandom_range(0, 5) == 0)
            skip = $urandom_range(1, rc - 1);
        seq = {seq, make_req(REQ_LOCAL, 5'($urandom_range(0, 31)), 16'($urandom()))};
        for (i = 1; i < rc; i++)
            if (i != skip)
                seq = {seq, make_req(REQ_SIGNAL, 5'(i), id)};
        if (!ordered)
        begin
            if (rc > 1 && $urandom_range(0, 3) == 0)
                seq = {seq, make_req(REQ_SIGNAL, 5'($urandom_range(1, rc - 1)),
                                     id + 16'd1)};
            for (i = seq.size() - 1; i > 0; i--)
            begin
                j      = $urandom_range(0, i);
                tmp    = seq[i];
                seq[i] = seq[j];
                seq[j] = tmp;
            end
        end
        for (i = 0; i < seq.size(); i++)
        begin
            if (!ordered && $urandom_range(0, 7) == 0)
                send_req(noise_req());
            send_req(seq[i]);
        end
        send_req(make_req(REQ_CROSSED, 5'($urandom_range(0, 31)), 16'($urandom())));
    endtask

    // Reset settings: single node, one round
    task test_reset_defaults();
        send_req(make_req(REQ_LOCAL, 5'd31, 16'hFFFF));
        send_req(make_req(REQ_SIGNAL, 5'd3, 16'hFFFF));
        send_req(make_req(REQ_UNUSED, 5'd7, 16'h1234));
        send_req(make_req(REQ_CROSSED, 5'd0, 16'h0000));
    endtask

    // All rounds pre-cleared, then entry cascades through every round
    task test_full_cascade();
        int i;
        set_node(16'd0, 17'd65536, 5'd17);
        for (i = 1; i < MAX_ROUNDS; i++)
            send_req(make_req(REQ_SIGNAL, 5'(i), barrier_id));
        send_req(make_req(REQ_SIGNAL, 5'd31, barrier_id));
        send_req(make_req(REQ_LOCAL, 5'd0, 16'h0000));
        send_req(make_req(REQ_CROSSED, 5'd0, 16'h0000));
    endtask

    // Zero node count, oversized and zero round counts
    task test_odd_settings();
        set_node(16'hFFFF, 17'd0, 5'd31);
        send_req(make_req(REQ_LOCAL, 5'd0, 16'h0000));
        set_node(16'd0, 17'd1, 5'd0);
        send_req(make_req(REQ_CROSSED, 5'd0, 16'h0000));
        send_req(make_req(REQ_SIGNAL, 5'd2, 16'h0005));
    endtask

    task test_random_barriers();
        while (items_sent < 170)
        begin
            pick_random_node();
            repeat ($urandom_range(1, 3))
            begin
                req_gaps   = ($urandom_range(0, 2) != 0);
                res_stalls = ($urandom_range(0, 2) != 0);
                run_barrier(1'b0);
            end
        end
    endtask

    // Output held off while requests keep coming: the node has to back up
    task test_output_hold();
        req_gaps   = 1'b0;
        res_stalls = 1'b0;
        set_node(16'd0, 17'd65536, 5'd17);
        hold_request = 1'b1;
        run_barrier(1'b1);
    endtask

    // Closing stretch at full rate on both sides
    task test_steady_stream();
        req_gaps   = 1'b0;
        res_stalls = 1'b0;
        pick_random_node();
        repeat (2) run_barrier(1'b0);
    endtask

    // Receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_ready <= 1'b1;
            end
            else if (res_stalls && $urandom_range(0, 4) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Message monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_ready === 1'b1)
        begin
            results_checked++;
            if (owed_msgs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected message kind=%0d dest=%0d round=%0d id=%0d last=%0d",
                             res_data.out_kind, res_data.dest_node, res_data.out_round,
                             res_data.out_barrier_id, res_data.last);
            end
            else
            begin
                want = owed_msgs[0];
                owed_msgs.delete(0);
                if (res_data.out_kind !== want.out_kind ||
                    res_data.dest_node !== want.dest_node ||
                    res_data.out_round !== want.out_round ||
                    res_data.out_barrier_id !== want.out_barrier_id ||
                    res_data.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("ERROR: exp kind=%0d dest=%0d round=%0d id=%0d last=%0d",
                                 want.out_kind, want.dest_node, want.out_round,
                                 want.out_barrier_id, want.last);
                        $display("       got kind=%0d dest=%0d round=%0d id=%0d last=%0d",
                                 res_data.out_kind, res_data.dest_node, res_data.out_round,
                                 res_data.out_barrier_id, res_data.last);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : main_flow
        int p;
        int r;
        for (p = 0; p < 2; p++)
            for (r = 0; r < MAX_ROUNDS; r++)
                flag_mem[p][r] = 16'hFFFF;
        at_round   = '0;
        barrier_id = '0;
        rank_cfg   = '0;
        count_cfg  = 17'd1;
        rounds_cfg = 5'd1;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_full_cascade();
        test_odd_settings();
        test_random_barriers();
        test_output_hold();
        test_steady_stream();

        // Drain, bounded
        req_valid <= 1'b0;
        for (p = 0; p < 4000 && owed_msgs.size() != 0; p++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (owed_msgs.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d predicted messages never delivered", owed_msgs.size());
        end

        $display("Sent %0d barrier requests under %0d node settings; checked %0d messages.",
                 items_sent, settings_used, results_checked);
        $display("Longest cascade from a single request: %0d messages.", longest_burst);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
